// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
// they expect clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("%m: check failed");

`endif

// ===== design/bc128_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc128_pkg
// Types, round constants and round functions of the 128-bit direct-key cipher.
// ----------------------------------------------------------------------------
package bc128_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 16;
  localparam int unsigned RC_SLOTS        = 17;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 64;

  // paddr bit that selects the key half
  localparam int unsigned KEY_SEL_BIT = 3;
  localparam logic KEY_SEL_LOW  = 1'b0;
  localparam logic KEY_SEL_HIGH = 1'b1;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  localparam logic [7:0] ROUND_CONST [RC_SLOTS] = '{
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A, 8'h2F,
    8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  // word 0 in the low 32 bits
  typedef logic [3:0][31:0] state_t;

  typedef struct packed {
    logic   dir;
    state_t s;
  } stage_t;

  function automatic logic [31:0] mix_word(logic [31:0] t);
    return t ^ {t[7:0], t[31:8]} ^ {t[23:0], t[31:24]};
  endfunction

  function automatic state_t theta(state_t k, state_t s);
    state_t      r;
    logic [31:0] t;
    r = s;
    t = mix_word(r[0] ^ r[2]);
    r[1] = r[1] ^ t;
    r[3] = r[3] ^ t;
    r = r ^ k;
    t = mix_word(r[1] ^ r[3]);
    r[0] = r[0] ^ t;
    r[2] = r[2] ^ t;
    return r;
  endfunction

  function automatic state_t gamma_step(state_t s);
    state_t      r;
    logic [31:0] t;
    r = s;
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    t    = r[3];
    r[3] = r[0];
    r[0] = t;
    r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    return r;
  endfunction

  function automatic state_t one_round(state_t k, state_t s, logic [7:0] pre,
                                       logic [7:0] post);
    state_t r;
    r = s;
    r[0] = r[0] ^ {24'h0, pre};
    r = theta(k, r);
    r[0] = r[0] ^ {24'h0, post};
    // pi1
    r[1] = {r[1][30:0], r[1][31]};
    r[2] = {r[2][26:0], r[2][31:27]};
    r[3] = {r[3][29:0], r[3][31:30]};
    r = gamma_step(r);
    // pi2
    r[1] = {r[1][0], r[1][31:1]};
    r[2] = {r[2][4:0], r[2][31:5]};
    r[3] = {r[3][1:0], r[3][31:2]};
    return r;
  endfunction

endpackage

// ===== design/block_cipher_128_direct_key_unit.sv =====
`timescale 1ns / 1ps
// a started block passes the input register, the round stages and the output register to the result
// throughput: one block per cycle, one register stage per round in the chain
// busy_o stays low: the pipeline never stalls since results cannot be held off
// reset clears the key registers to zero and every stage valid bit at once
// ----------------------------------------------------------------------------
// block_cipher_128_direct_key_unit
// Pipelined 128-bit block cipher in direct-key mode with an APB key port.
// ----------------------------------------------------------------------------
module block_cipher_128_direct_key_unit #(
  parameter int unsigned ROUND_COUNT = bc128_pkg::ROUND_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [63:0]                   block_low_i,
  input  logic [63:0]                   block_high_i,
  // result side
  output logic                          result_valid_o,
  output logic [63:0]                   result_low_o,
  output logic [63:0]                   result_high_o,
  // key port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bc128_pkg::ADDR_W-1:0]  paddr,
  input  logic [bc128_pkg::DATA_W-1:0]  pwdata,
  output logic [bc128_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [63:0] key_low_q, key_high_q;
  logic        cfg_write;

  bc128_pkg::state_t key, wkey;

  logic              stg_valid [ROUND_COUNT+1];
  bc128_pkg::stage_t stg_data  [ROUND_COUNT+1];

  logic              in_valid_q;
  bc128_pkg::stage_t in_stage_q;

  logic              out_valid_q;
  bc128_pkg::state_t out_q, out_d;

  // key registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_write) begin
      unique case (paddr[bc128_pkg::KEY_SEL_BIT])
        bc128_pkg::KEY_SEL_LOW:  key_low_q  <= pwdata;
        bc128_pkg::KEY_SEL_HIGH: key_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[bc128_pkg::KEY_SEL_BIT])
      bc128_pkg::KEY_SEL_LOW:  prdata = key_low_q;
      bc128_pkg::KEY_SEL_HIGH: prdata = key_high_q;
      default:                 prdata = '0;
    endcase
  end

  // the user must rewrite the key only while the pipeline is empty; the block does not enforce this
  assign key  = {key_high_q, key_low_q};
  assign wkey = bc128_pkg::theta('0, key);

  assign busy_o = 1'b0;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_stage_q.dir <= req_type_i;
      in_stage_q.s   <= {block_high_i, block_low_i};
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_data[0]  = in_stage_q;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    bc128_round #(
      .ROUND_COUNT (ROUND_COUNT),
      .ROUND_IDX   (r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[r]),
      .stage_i (stg_data[r]),
      .key_i   (key),
      .wkey_i  (wkey),
      .valid_o (stg_valid[r+1]),
      .stage_o (stg_data[r+1])
    );
  end

  // final theta and outer constant
  always_comb begin
    out_d = stg_data[ROUND_COUNT].s;
    if (stg_data[ROUND_COUNT].dir == bc128_pkg::DIR_DEC) begin
      out_d    = bc128_pkg::theta(wkey, out_d);
      out_d[0] = out_d[0] ^ {24'h0, bc128_pkg::ROUND_CONST[0]};
    end else begin
      out_d[0] = out_d[0] ^ {24'h0, bc128_pkg::ROUND_CONST[ROUND_COUNT]};
      out_d    = bc128_pkg::theta(key, out_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= stg_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid[ROUND_COUNT]) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_low_o   = {out_q[1], out_q[0]};
  assign result_high_o  = {out_q[3], out_q[2]};

endmodule

// ===== design/bc128_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc128_round
// One registered round stage; direction picks key and constant placement.
// ----------------------------------------------------------------------------
module bc128_round #(
  parameter int unsigned ROUND_COUNT = bc128_pkg::ROUND_COUNT_DEF,
  parameter int unsigned ROUND_IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bc128_pkg::stage_t  stage_i,
  input  bc128_pkg::state_t  key_i,
  input  bc128_pkg::state_t  wkey_i,
  output logic               valid_o,
  output bc128_pkg::stage_t  stage_o
);

  localparam logic [7:0] EncRc = bc128_pkg::ROUND_CONST[ROUND_IDX];
  localparam logic [7:0] DecRc = bc128_pkg::ROUND_CONST[ROUND_COUNT - ROUND_IDX];

  logic              valid_q;
  bc128_pkg::stage_t stage_q, stage_d;

  always_comb begin
    stage_d.dir = stage_i.dir;
    if (stage_i.dir == bc128_pkg::DIR_DEC) begin
      stage_d.s = bc128_pkg::one_round(wkey_i, stage_i.s, 8'h00, DecRc);
    end else begin
      stage_d.s = bc128_pkg::one_round(key_i, stage_i.s, EncRc, 8'h00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== design/bc128_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc128_checker
// Port-level checks on latency, the key port and the command handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bc128_checker #(
  parameter int unsigned ROUND_COUNT = bc128_pkg::ROUND_COUNT_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bc128_pkg::ADDR_W-1:0]  paddr,
  input logic [bc128_pkg::DATA_W-1:0]  pwdata,
  input logic [bc128_pkg::DATA_W-1:0]  prdata,
  input logic                          pready
);

  localparam int unsigned Latency = ROUND_COUNT + 2;

  logic cmd_xfer, key_low_wr;

  assign cmd_xfer   = start_i && !busy_o;
  assign key_low_wr = psel && penable && pwrite && pready &&
                      (paddr[bc128_pkg::KEY_SEL_BIT] == bc128_pkg::KEY_SEL_LOW);

  // every accepted block yields its strobe after the input register, the round stages and the output register
  `ASSERT_IMPL(a_latency, cmd_xfer, ##(Latency) result_valid_o)

  // a written low key half reads back on the following cycle while paddr still selects it
  `ASSERT_NEXT(a_key_readback, key_low_wr,
               (paddr[bc128_pkg::KEY_SEL_BIT] != bc128_pkg::KEY_SEL_LOW) ||
               (prdata == $past(pwdata)))

  // the pipeline never pushes back on commands or on the key port
  `ASSERT_ALWAYS(a_no_stall, !busy_o && pready)

endmodule

bind block_cipher_128_direct_key_unit bc128_checker #(
  .ROUND_COUNT (ROUND_COUNT)
) u_bc128_checker (.*);

// ===== dv/block_cipher_128_direct_key_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_128_direct_key_unit_tb
// Drives blocks through the pipelined cipher in both directions under a range
// of keys, predicts each output with a behavioural model of the cipher and
// compares every result strobe, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module block_cipher_128_direct_key_unit_tb;

  localparam int unsigned ROUNDS  = bc128_pkg::ROUND_COUNT_DEF;
  localparam int unsigned LATENCY = ROUNDS + 2;
  localparam int unsigned AW      = bc128_pkg::ADDR_W;
  localparam int unsigned DW      = bc128_pkg::DATA_W;

  // key halves sit 8 bytes apart
  localparam logic [AW-1:0] KEY_LOW_ADDR  = AW'(0);
  localparam logic [AW-1:0] KEY_HIGH_ADDR = AW'(8);

  localparam logic [7:0] RC_START = 8'h80;
  localparam logic [7:0] RC_POLY  = 8'h1B;

  typedef struct packed {
    logic        dir;
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_out_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic          req_type_i;
  logic [63:0]   block_low_i;
  logic [63:0]   block_high_i;
  logic          result_valid_o;
  logic [63:0]   result_low_o;
  logic [63:0]   result_high_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  cipher_out_t   pending_results[$];
  logic [63:0]   key_low_model;
  logic [63:0]   key_high_model;
  int unsigned   idle_pct;
  int unsigned   fail_count;
  int unsigned   enc_checked;
  int unsigned   dec_checked;
  int unsigned   key_settings;

  block_cipher_128_direct_key_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .block_low_i    (block_low_i),
    .block_high_i   (block_high_i),
    .result_valid_o (result_valid_o),
    .result_low_o   (result_low_o),
    .result_high_o  (result_high_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rotl32(logic [31:0] w, int unsigned n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic logic [31:0] diffuse(logic [31:0] w);
    return w ^ rotl32(w, 8) ^ rotl32(w, 24);
  endfunction

  function automatic logic [7:0] round_const(int unsigned idx);
    logic [7:0] rc;
    rc = RC_START;
    repeat (idx) rc = {rc[6:0], 1'b0} ^ (rc[7] ? RC_POLY : 8'h00);
    return rc;
  endfunction

  function automatic bc128_pkg::state_t lin_mix(bc128_pkg::state_t key,
                                                bc128_pkg::state_t st);
    logic [31:0] t;
    t = diffuse(st[0] ^ st[2]);
    st[1] ^= t;
    st[3] ^= t;
    st ^= key;
    t = diffuse(st[1] ^ st[3]);
    st[0] ^= t;
    st[2] ^= t;
    return st;
  endfunction

  function automatic bc128_pkg::state_t nonlin(bc128_pkg::state_t st);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = st;
    b ^= ~(d | c);
    a ^= c & b;
    {a, d} = {d, a};
    c ^= a ^ b ^ d;
    b ^= ~(d | c);
    a ^= c & b;
    return {d, c, b, a};
  endfunction

  function automatic bc128_pkg::state_t cipher_round(bc128_pkg::state_t key,
                                                     bc128_pkg::state_t st,
                                                     logic [7:0] pre, logic [7:0] post);
    st[0][7:0] ^= pre;
    st = lin_mix(key, st);
    st[0][7:0] ^= post;
    st[1] = rotl32(st[1], 1);
    st[2] = rotl32(st[2], 5);
    st[3] = rotl32(st[3], 2);
    st = nonlin(st);
    st[1] = rotl32(st[1], 31);
    st[2] = rotl32(st[2], 27);
    st[3] = rotl32(st[3], 30);
    return st;
  endfunction

  function automatic cipher_out_t predict_block(logic dir, logic [63:0] lo, logic [63:0] hi);
    bc128_pkg::state_t st;
    bc128_pkg::state_t key;
    cipher_out_t       res;
    st  = {hi, lo};
    key = {key_high_model, key_low_model};
    if (dir == bc128_pkg::DIR_ENC) begin
      for (int r = 0; r < ROUNDS; r++) st = cipher_round(key, st, round_const(r), 8'h00);
      st[0][7:0] ^= round_const(ROUNDS);
      st = lin_mix(key, st);
    end else begin
      // working key is rebuilt from the programmed key for each block
      key = lin_mix('0, key);
      for (int r = ROUNDS; r >= 1; r--) st = cipher_round(key, st, 8'h00, round_const(r));
      st = lin_mix(key, st);
      st[0][7:0] ^= round_const(0);
    end
    res.dir = dir;
    res.lo  = {st[1], st[0]};
    res.hi  = {st[3], st[2]};
    return res;
  endfunction

  function automatic logic [63:0] random_word64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : check_results
    cipher_out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with nothing pending: low %h high %h",
               result_low_o, result_high_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_low_o !== want.lo) begin
          $error("result_low: expected %h, actual %h", want.lo, result_low_o);
          fail_count++;
        end
        if (result_high_o !== want.hi) begin
          $error("result_high: expected %h, actual %h", want.hi, result_high_o);
          fail_count++;
        end
        if (want.dir == bc128_pkg::DIR_ENC) enc_checked++;
        else dec_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_block(input logic dir, input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= dir;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(predict_block(dir, lo, hi));
  endtask

  // lets the pipeline empty before any key port access
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [AW-1:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == KEY_LOW_ADDR) key_low_model = data;
    else key_high_model = data;
    @(posedge clk_i);
  endtask

  task automatic read_key(input logic [AW-1:0] addr, input logic [63:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata at %h: expected %h, actual %h", addr, want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_key_regs();
    read_key(KEY_LOW_ADDR, key_low_model);
    read_key(KEY_HIGH_ADDR, key_high_model);
  endtask

  task automatic program_key(input logic [63:0] lo, input logic [63:0] hi);
    write_key(KEY_LOW_ADDR, lo);
    write_key(KEY_HIGH_ADDR, hi);
    check_key_regs();
    key_settings++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    check_key_regs();
    send_block(bc128_pkg::DIR_ENC, '0, '0);
    send_block(bc128_pkg::DIR_DEC, '0, '0);
    wait_drained();
  endtask

  task automatic test_block_extremes();
    logic [63:0] pattern [4];
    pattern = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    program_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    for (int i = 0; i < 4; i++) begin
      send_block(bc128_pkg::DIR_ENC, pattern[i], pattern[3 - i]);
      send_block(bc128_pkg::DIR_DEC, pattern[i], pattern[i]);
    end
    wait_drained();
  endtask

  task automatic test_key_extremes();
    logic [63:0] klo [3];
    logic [63:0] khi [3];
    klo = '{'1, '1, '0};
    khi = '{'1, '0, '1};
    for (int i = 0; i < 3; i++) begin
      program_key(klo[i], khi[i]);
      send_block(bc128_pkg::DIR_ENC, random_word64(), random_word64());
      send_block(bc128_pkg::DIR_DEC, random_word64(), random_word64());
      wait_drained();
    end
  endtask

  // encrypt then decrypt of the predicted ciphertext should give
  // the plaintext back, and the key registers must be left untouched
  task automatic test_round_trip();
    logic [63:0] lo, hi;
    cipher_out_t ct;
    program_key(random_word64(), random_word64());
    repeat (2) begin
      lo = random_word64();
      hi = random_word64();
      ct = predict_block(bc128_pkg::DIR_ENC, lo, hi);
      send_block(bc128_pkg::DIR_ENC, lo, hi);
      send_block(bc128_pkg::DIR_DEC, ct.lo, ct.hi);
    end
    wait_drained();
    check_key_regs();
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned chunks,
                                     input int unsigned per_chunk);
    int unsigned  sent;
    int unsigned  kind;
    logic [63:0]  lo, hi;
    logic [127:0] sparse;
    cipher_out_t  ct;
    idle_pct = pct;
    for (int c = 0; c < chunks; c++) begin
      kind = $urandom_range(5);
      case (kind)
        0: program_key('0, '0);
        1: program_key('1, '1);
        default: program_key(random_word64(), random_word64());
      endcase
      sent = 0;
      while (sent < per_chunk) begin
        kind = $urandom_range(9);
        if (kind <= 5) begin
          send_block(1'($urandom_range(1)), random_word64(), random_word64());
          sent++;
        end else if (kind <= 7) begin
          lo = random_word64();
          hi = random_word64();
          ct = predict_block(bc128_pkg::DIR_ENC, lo, hi);
          send_block(bc128_pkg::DIR_ENC, lo, hi);
          send_block(bc128_pkg::DIR_DEC, ct.lo, ct.hi);
          sent += 2;
        end else begin
          // single set or single clear bit
          sparse = 128'b1 << $urandom_range(127);
          if ($urandom_range(1) == 1) sparse = ~sparse;
          send_block(1'($urandom_range(1)), sparse[63:0], sparse[127:64]);
          sent++;
        end
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    req_type_i     <= bc128_pkg::DIR_ENC;
    block_low_i    <= '0;
    block_high_i   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    key_low_model  = '0;
    key_high_model = '0;
    idle_pct       = 7;
    fail_count     = 0;
    enc_checked    = 0;
    dec_checked    = 0;
    key_settings   = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_block_extremes();
    test_key_extremes();
    test_round_trip();
    test_random_traffic(7, 4, 142);
    test_random_traffic(46, 4, 142);
    test_random_traffic(0, 4, 142);

    $display("checked %0d encrypted and %0d decrypted blocks under %0d key settings",
             enc_checked, dec_checked, key_settings);
    $display("sender gaps at 7 and 46 per cent and none; extreme blocks and keys, "
             , "round trips and single-bit blocks included");
    if (fail_count == 0) begin
      $display("block_cipher_128_direct_key_unit test passed");
    end else begin
      $display("block_cipher_128_direct_key_unit test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("block_cipher_128_direct_key_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bc128_pkg.sv
design/bc128_round.sv
design/block_cipher_128_direct_key_unit.sv
design/bc128_checker.sv
dv/block_cipher_128_direct_key_unit_tb.sv
